// ===== hw/rtl/msat_pkg.sv =====
package msat_pkg;

    localparam int unsigned MAX_SENSORS_DEF  = 16;
    localparam int unsigned ADDRESS_BITS_DEF = 4;
    localparam int unsigned SAMPLES_DEF      = 64;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned MOIST_W    = 14;
    localparam int unsigned THR_W      = 17;
    localparam int unsigned COUNT_CFG_W = 5;
    localparam int unsigned SENSOR_W   = 4;
    localparam int unsigned RECIP_W    = 20;
    localparam int unsigned NUM_W      = 32;

    localparam int unsigned FULL_SCALE       = 4095;
    localparam int unsigned SCALE_HUNDREDTHS = 10000;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic                   SCAN_ENABLED_RST   = 1'b1;
    localparam logic [COUNT_CFG_W-1:0] SENSOR_COUNT_RST   = 5'd16;
    localparam logic [THR_W-1:0]       HIGH_THRESHOLD_RST = 17'd100000;
    localparam logic [THR_W-1:0]       LOW_THRESHOLD_RST  = 17'd0;

    typedef enum logic [1:0] {
        REG_SCAN_ENABLED   = 2'd0,
        REG_SENSOR_COUNT   = 2'd1,
        REG_HIGH_THRESHOLD = 2'd2,
        REG_LOW_THRESHOLD  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_number;
        logic [SENSOR_W-1:0] next_mux_address;
        logic                scan_done;
    } result_meta_t;

endpackage

// ===== hw/rtl/msat_scale.sv =====
module msat_scale #(
    parameter int unsigned SAMPLES = msat_pkg::SAMPLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [msat_pkg::SUM_W-1:0]       in_sum,
    input  msat_pkg::result_meta_t           in_meta,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [msat_pkg::MOIST_W-1:0]     out_moisture,
    output msat_pkg::result_meta_t           out_meta
);

    localparam int unsigned SUM_W   = msat_pkg::SUM_W;
    localparam int unsigned MOIST_W = msat_pkg::MOIST_W;
    localparam int unsigned RECIP_W = msat_pkg::RECIP_W;
    localparam int unsigned NUM_W   = msat_pkg::NUM_W;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;

    localparam longint unsigned DIVISOR = longint'(SAMPLES) * msat_pkg::FULL_SCALE;
    // floor(2^SUM_W * 10000 / divisor): q0 is exact or one low
    localparam longint unsigned RECIP =
        ((64'd1 << SUM_W) * msat_pkg::SCALE_HUNDREDTHS) / DIVISOR;

    localparam logic [PROD_W-1:0] RECIP_C   = PROD_W'(RECIP);
    localparam logic [NUM_W-1:0]  DIVISOR_C = NUM_W'(DIVISOR);
    localparam logic [NUM_W-1:0]  HUND_C    = NUM_W'(msat_pkg::SCALE_HUNDREDTHS);

    logic                    a_valid_reg;
    logic [PROD_W-1:0]       a_prod_reg;
    logic [SUM_W-1:0]        a_sum_reg;
    msat_pkg::result_meta_t  a_meta_reg;

    logic                    b_valid_reg;
    logic [MOIST_W-1:0]      b_q0_reg;
    logic [NUM_W-1:0]        b_num_reg;
    logic [NUM_W-1:0]        b_lim_reg;
    msat_pkg::result_meta_t  b_meta_reg;

    logic                    c_valid_reg;
    logic [MOIST_W-1:0]      c_m_reg;
    msat_pkg::result_meta_t  c_meta_reg;

    logic                    a_ready;
    logic                    b_ready;
    logic                    c_ready;
    logic [PROD_W-1:0]       a_prod_next;
    logic [MOIST_W-1:0]      q0;
    logic [NUM_W-1:0]        b_num_next;
    logic [NUM_W-1:0]        b_lim_next;
    logic [MOIST_W-1:0]      c_m_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_prod_next = PROD_W'(in_sum) * RECIP_C;
    assign q0          = a_prod_reg[SUM_W +: MOIST_W];
    assign b_num_next  = NUM_W'(a_sum_reg) * HUND_C;
    assign b_lim_next  = (NUM_W'(q0) + NUM_W'(1)) * DIVISOR_C;
    assign c_m_next    = (b_num_reg >= b_lim_reg) ? b_q0_reg + MOIST_W'(1) : b_q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_prod_reg <= a_prod_next;
            a_sum_reg  <= in_sum;
            a_meta_reg <= in_meta;
        end
        if (a_valid_reg && b_ready)
        begin
            b_q0_reg   <= q0;
            b_num_reg  <= b_num_next;
            b_lim_reg  <= b_lim_next;
            b_meta_reg <= a_meta_reg;
        end
        if (b_valid_reg && c_ready)
        begin
            c_m_reg    <= c_m_next;
            c_meta_reg <= b_meta_reg;
        end
    end

    assign out_valid    = c_valid_reg;
    assign out_moisture = c_m_reg;
    assign out_meta     = c_meta_reg;

endmodule

// ===== hw/rtl/mux_sensor_scan_average_trigger.sv =====
// Multiplexed sensor scanner. Each request on the input channel is one 12-bit
// converter sample of the sensor the mux currently selects; with scan_enabled
// low samples are taken and dropped. After SAMPLES samples the sum is scaled
// to moisture in hundredths of a percent, floor(sum*10000/(SAMPLES*4095)),
// the sensor's high/low trigger flags are updated, and one result request
// carries the sensor number, moisture, flags, the next mux address and an
// end-of-scan mark. The block takes one sample per clock cycle while the
// result path does not stall it; a completed sum then passes in order through
// the input register and the scaling pipeline (reciprocal multiply,
// correction multiply, compare, flag update).
// Config registers (APB, byte addresses 0x0/0x4/0x8/0xC): scan_enabled,
// sensor_count, high_threshold, low_threshold; write them only while idle.
module mux_sensor_scan_average_trigger #(
    parameter int unsigned MAX_SENSORS  = msat_pkg::MAX_SENSORS_DEF,
    parameter int unsigned ADDRESS_BITS = msat_pkg::ADDRESS_BITS_DEF,
    parameter int unsigned SAMPLES      = msat_pkg::SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msat_pkg::PADDR_W-1:0]      paddr,
    input  logic [msat_pkg::PDATA_W-1:0]      pwdata,
    output logic [msat_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [msat_pkg::SAMPLE_W-1:0]     adc_sample,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [msat_pkg::SENSOR_W-1:0]     sensor_number,
    output logic [msat_pkg::MOIST_W-1:0]      moisture,
    output logic                              above_high,
    output logic                              below_low,
    output logic [msat_pkg::SENSOR_W-1:0]     next_mux_address,
    output logic                              scan_done
);

    localparam int unsigned SUM_W    = msat_pkg::SUM_W;
    localparam int unsigned MOIST_W  = msat_pkg::MOIST_W;
    localparam int unsigned THR_W    = msat_pkg::THR_W;
    localparam int unsigned CCNT_W   = msat_pkg::COUNT_CFG_W;
    localparam int unsigned SENSOR_W = msat_pkg::SENSOR_W;
    localparam int unsigned PDATA_W  = msat_pkg::PDATA_W;
    localparam int unsigned IDX_W    = $clog2(MAX_SENSORS);
    localparam int unsigned CNT_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    localparam logic [CNT_W-1:0]    LAST_SAMPLE = CNT_W'(SAMPLES - 1);
    localparam logic [CCNT_W-1:0]   MAX_COUNT   = CCNT_W'(MAX_SENSORS);
    localparam logic [SENSOR_W-1:0] ADDR_MASK   = SENSOR_W'((1 << ADDRESS_BITS) - 1);

    // config
    logic                   scan_enabled_reg;
    logic [CCNT_W-1:0]      sensor_count_reg;
    logic [THR_W-1:0]       high_threshold_reg;
    logic [THR_W-1:0]       low_threshold_reg;
    logic                   cfg_write;
    msat_pkg::reg_idx_t     cfg_sel;

    // accumulation
    logic [SUM_W-1:0]       sample_sum_reg;
    logic [CNT_W-1:0]       sample_count_reg;
    logic [IDX_W-1:0]       sensor_index_reg;
    logic                   acc_fire;
    logic                   last_sample;
    logic [SUM_W-1:0]       sum_add;
    logic [CCNT_W-1:0]      eff_count;
    logic                   last_sensor;
    logic [IDX_W-1:0]       next_index;

    // input register to the scaler
    logic                   s1_valid_reg;
    logic [SUM_W-1:0]       s1_sum_reg;
    msat_pkg::result_meta_t s1_meta_reg;
    logic                   s1_ready;
    logic                   sc_in_ready;

    // scaler output
    logic                   sc_valid;
    logic [MOIST_W-1:0]     sc_moisture;
    msat_pkg::result_meta_t sc_meta;

    // flags and result register
    logic [MAX_SENSORS-1:0] high_flags_reg;
    logic [MAX_SENSORS-1:0] low_flags_reg;
    logic                   out_valid_reg;
    logic [SENSOR_W-1:0]    sensor_number_reg;
    logic [MOIST_W-1:0]     moisture_reg;
    logic                   above_high_reg;
    logic                   below_low_reg;
    logic [SENSOR_W-1:0]    next_mux_address_reg;
    logic                   scan_done_reg;
    logic                   o_ready;
    logic                   res_fire;
    logic [IDX_W-1:0]       flag_idx;
    logic [THR_W-1:0]       m_ext;
    logic                   hf_cur;
    logic                   lf_cur;
    logic                   hf_new;
    logic                   lf_new;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = msat_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enabled_reg   <= msat_pkg::SCAN_ENABLED_RST;
            sensor_count_reg   <= msat_pkg::SENSOR_COUNT_RST;
            high_threshold_reg <= msat_pkg::HIGH_THRESHOLD_RST;
            low_threshold_reg  <= msat_pkg::LOW_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                msat_pkg::REG_SCAN_ENABLED:   scan_enabled_reg   <= pwdata[0];
                msat_pkg::REG_SENSOR_COUNT:   sensor_count_reg   <= pwdata[CCNT_W-1:0];
                msat_pkg::REG_HIGH_THRESHOLD: high_threshold_reg <= pwdata[THR_W-1:0];
                msat_pkg::REG_LOW_THRESHOLD:  low_threshold_reg  <= pwdata[THR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            msat_pkg::REG_SCAN_ENABLED:   prdata = PDATA_W'(scan_enabled_reg);
            msat_pkg::REG_SENSOR_COUNT:   prdata = PDATA_W'(sensor_count_reg);
            msat_pkg::REG_HIGH_THRESHOLD: prdata = PDATA_W'(high_threshold_reg);
            msat_pkg::REG_LOW_THRESHOLD:  prdata = PDATA_W'(low_threshold_reg);
        endcase
    end

    // ---------------- accumulation ----------------
    assign s1_ready    = !s1_valid_reg || sc_in_ready;
    assign in_ready    = s1_ready;
    assign acc_fire    = in_valid && in_ready && scan_enabled_reg;
    assign sum_add     = sample_sum_reg + SUM_W'(adc_sample);
    assign last_sample = (sample_count_reg == LAST_SAMPLE);

    always_comb
    begin
        if (sensor_count_reg == '0)
        begin
            eff_count = CCNT_W'(1);
        end
        else if (sensor_count_reg > MAX_COUNT)
        begin
            eff_count = MAX_COUNT;
        end
        else
        begin
            eff_count = sensor_count_reg;
        end
    end

    assign last_sensor = (CCNT_W'(sensor_index_reg) + CCNT_W'(1)) >= eff_count;
    assign next_index  = last_sensor ? '0 : sensor_index_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            sensor_index_reg <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (acc_fire)
            begin
                if (last_sample)
                begin
                    sample_sum_reg   <= '0;
                    sample_count_reg <= '0;
                    sensor_index_reg <= next_index;
                end
                else
                begin
                    sample_sum_reg   <= sum_add;
                    sample_count_reg <= sample_count_reg + CNT_W'(1);
                end
            end
            if (s1_ready)
            begin
                s1_valid_reg <= acc_fire && last_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire && last_sample)
        begin
            s1_sum_reg                    <= sum_add;
            s1_meta_reg.sensor_number     <= SENSOR_W'(sensor_index_reg);
            s1_meta_reg.next_mux_address  <= SENSOR_W'(next_index) & ADDR_MASK;
            s1_meta_reg.scan_done         <= last_sensor;
        end
    end

    // ---------------- scaling ----------------
    msat_scale #(
        .SAMPLES (SAMPLES)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s1_valid_reg),
        .in_ready     (sc_in_ready),
        .in_sum       (s1_sum_reg),
        .in_meta      (s1_meta_reg),
        .out_valid    (sc_valid),
        .out_ready    (o_ready),
        .out_moisture (sc_moisture),
        .out_meta     (sc_meta)
    );

    // ---------------- trigger flags and result ----------------
    assign o_ready  = !out_valid_reg || out_ready;
    assign res_fire = sc_valid && o_ready;
    assign flag_idx = sc_meta.sensor_number[IDX_W-1:0];
    assign m_ext    = THR_W'(sc_moisture);
    assign hf_cur   = high_flags_reg[flag_idx];
    assign lf_cur   = low_flags_reg[flag_idx];

    // first matching rule wins
    always_comb
    begin
        hf_new = hf_cur;
        lf_new = lf_cur;
        if (m_ext >= high_threshold_reg && !hf_cur)
        begin
            hf_new = 1'b1;
        end
        else if (m_ext < high_threshold_reg && hf_cur)
        begin
            hf_new = 1'b0;
        end
        else if (m_ext <= low_threshold_reg && !lf_cur)
        begin
            lf_new = 1'b1;
        end
        else if (m_ext > low_threshold_reg && lf_cur)
        begin
            lf_new = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_flags_reg <= '0;
            low_flags_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res_fire)
            begin
                high_flags_reg[flag_idx] <= hf_new;
                low_flags_reg[flag_idx]  <= lf_new;
            end
            if (o_ready)
            begin
                out_valid_reg <= sc_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            sensor_number_reg    <= sc_meta.sensor_number;
            moisture_reg         <= sc_moisture;
            above_high_reg       <= hf_new;
            below_low_reg        <= lf_new;
            next_mux_address_reg <= sc_meta.next_mux_address;
            scan_done_reg        <= sc_meta.scan_done;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sensor_number    = sensor_number_reg;
    assign moisture         = moisture_reg;
    assign above_high       = above_high_reg;
    assign below_low        = below_low_reg;
    assign next_mux_address = next_mux_address_reg;
    assign scan_done        = scan_done_reg;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    import msat_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int ITEM_TARGET    = 1850;
    localparam int READING_TARGET = 20;
    localparam int PRESSURE_PHASE = 2;
    localparam int STALL_CYCLES   = 1500;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [MOIST_W-1:0]  level;
        logic                above_high;
        logic                below_low;
        logic [SENSOR_W-1:0] next_addr;
        logic                scan_done;
    } reading_t;

    logic clk;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] adc_sample = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SENSOR_W-1:0] sensor_number;
    logic [MOIST_W-1:0]  moisture;
    logic                above_high;
    logic                below_low;
    logic [SENSOR_W-1:0] next_mux_address;
    logic                scan_done;

    // model of the scanner
    logic                   cfg_scan_enabled;
    logic [COUNT_CFG_W-1:0] cfg_sensor_count;
    logic [THR_W-1:0]       cfg_high_thr;
    logic [THR_W-1:0]       cfg_low_thr;
    logic [SUM_W-1:0]       acc_sum;
    int unsigned            acc_count;
    logic [SENSOR_W-1:0]    cur_sensor;
    logic [15:0]            alarm_high;
    logic [15:0]            alarm_low;

    logic [SAMPLE_W-1:0] pending_samples[$];
    reading_t            expected_readings[$];

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   tx_wait     = 0;
    int   tx_gap_max  = 15;
    int   rx_wait     = 0;
    int   rx_gap_max  = 15;
    int   rx_stall_left     = 0;
    int   rx_stall_len      = 0;
    int   rx_stall_requests = 0;
    int   rx_stall_served   = 0;
    int   cycle_count    = 0;
    int   error_count    = 0;
    int   items_queued   = 0;
    int   readings_seen  = 0;
    int   hi_level       = 2048;
    int   lo_level       = 1024;

    mux_sensor_scan_average_trigger u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sensor_number    (sensor_number),
        .moisture         (moisture),
        .above_high       (above_high),
        .below_low        (below_low),
        .next_mux_address (next_mux_address),
        .scan_done        (scan_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic [31:0] reg_mask(input reg_idx_t idx);
        case (idx)
            REG_SCAN_ENABLED: return 32'h1;
            REG_SENSOR_COUNT: return (32'h1 << COUNT_CFG_W) - 1;
            default:          return (32'h1 << THR_W) - 1;
        endcase
    endfunction

    task automatic apply_config(input reg_idx_t idx, input logic [31:0] value);
        case (idx)
            REG_SCAN_ENABLED:   cfg_scan_enabled = value[0];
            REG_SENSOR_COUNT:   cfg_sensor_count = value[COUNT_CFG_W-1:0];
            REG_HIGH_THRESHOLD: cfg_high_thr     = value[THR_W-1:0];
            REG_LOW_THRESHOLD:  cfg_low_thr      = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    // accumulate one sample; a full set yields one sensor reading
    task automatic predict_reading(input logic [SAMPLE_W-1:0] value);
        reading_t    r;
        longint unsigned num;
        int unsigned m;
        int unsigned n;
        logic        hf;
        logic        lf;
        if (!cfg_scan_enabled)
            return;
        acc_sum = acc_sum + value;
        acc_count++;
        if (acc_count < SAMPLES_DEF)
            return;
        num = longint'(acc_sum) * SCALE_HUNDREDTHS;
        m = int'(num / (SAMPLES_DEF * FULL_SCALE));
        acc_sum = '0;
        acc_count = 0;
        hf = alarm_high[cur_sensor];
        lf = alarm_low[cur_sensor];
        if (m >= cfg_high_thr && !hf)
            hf = 1'b1;
        else if (m < cfg_high_thr && hf)
            hf = 1'b0;
        else if (m <= cfg_low_thr && !lf)
            lf = 1'b1;
        else if (m > cfg_low_thr && lf)
            lf = 1'b0;
        alarm_high[cur_sensor] = hf;
        alarm_low[cur_sensor] = lf;
        n = cfg_sensor_count;
        if (n < 1)
            n = 1;
        if (n > MAX_SENSORS_DEF)
            n = MAX_SENSORS_DEF;
        r.sensor = cur_sensor;
        r.level = m[MOIST_W-1:0];
        r.above_high = hf;
        r.below_low = lf;
        if (cur_sensor + 1 >= n)
        begin
            r.next_addr = '0;
            r.scan_done = 1'b1;
        end
        else
        begin
            r.next_addr = cur_sensor + 1'b1;
            r.scan_done = 1'b0;
        end
        cur_sensor = r.next_addr;
        expected_readings.push_back(r);
    endtask

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
            cfg_scan_enabled = SCAN_ENABLED_RST;
            cfg_sensor_count = SENSOR_COUNT_RST;
            cfg_high_thr = HIGH_THRESHOLD_RST;
            cfg_low_thr = LOW_THRESHOLD_RST;
            acc_sum = '0;
            acc_count = 0;
            cur_sensor = '0;
            alarm_high = '0;
            alarm_low = '0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (psel && penable && pwrite && pready)
                apply_config(reg_idx_t'(paddr[3:2]), pwdata);
            if (out_valid && out_ready)
            begin
                got = '{sensor_number, moisture, above_high, below_low,
                        next_mux_address, scan_done};
                readings_seen++;
                if (expected_readings.size() == 0)
                begin
                    note_error($sformatf("unexpected reading: sensor %0d moisture %0d",
                                         sensor_number, moisture));
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.sensor !== want.sensor || got.level !== want.level ||
                        got.above_high !== want.above_high ||
                        got.below_low !== want.below_low ||
                        got.next_addr !== want.next_addr ||
                        got.scan_done !== want.scan_done)
                        note_error($sformatf({"reading mismatch: expected sensor %0d ",
                            "moisture %0d hi %0b lo %0b next %0d done %0b, ",
                            "got sensor %0d moisture %0d hi %0b lo %0b next %0d done %0b"},
                            want.sensor, want.level, want.above_high, want.below_low,
                            want.next_addr, want.scan_done, got.sensor, got.level,
                            got.above_high, got.below_low, got.next_addr,
                            got.scan_done));
                end
            end
            if (in_valid && in_ready)
                predict_reading(adc_sample);
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                adc_sample <= pending_samples.pop_front();
                in_valid <= 1'b1;
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // reading receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end
        else if (rx_stall_served != rx_stall_requests)
        begin
            rx_stall_served = rx_stall_requests;
            rx_stall_left = rx_stall_len;
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_taken)
                rx_wait = $urandom_range(0, rx_gap_max);
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] value,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== (want & reg_mask(idx)))
            note_error($sformatf("register %s readback: expected 0x%0h, got 0x%0h",
                                 idx.name(), want & reg_mask(idx), got));
    endtask

    task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, value, unused);
        check_reg(idx, value);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_noise(input int count, input bit counted);
        repeat (count)
            pending_samples.push_back(SAMPLE_W'($urandom_range(0, 4095)));
        if (counted)
            items_queued += count;
    endtask

    // one full sample set around a level; wide spread means uniform samples
    task automatic queue_block(input int level, input int spread);
        int v;
        repeat (SAMPLES_DEF)
        begin
            if (spread >= 2048)
                v = $urandom_range(0, 4095);
            else
                v = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            pending_samples.push_back(v[SAMPLE_W-1:0]);
        end
        items_queued += SAMPLES_DEF;
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 4095;
            2: return hi_level;
            3: return $urandom_range(0, 1) ? hi_level + 1 : hi_level - 1;
            4: return lo_level;
            5: return $urandom_range(0, 1) ? lo_level + 1 : lo_level - 1;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(0, 5))
            0: return 4095;
            1: return 40;
            2: return 3;
            default: return 0;
        endcase
    endfunction

    // a random level; in the default case its constant set lands exactly on the returned threshold
    function automatic logic [THR_W-1:0] pick_threshold(output int level);
        level = $urandom_range(0, 4095);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return THR_W'(SCALE_HUNDREDTHS);
            2: return THR_W'(100000);
            3: return '1;
            default: return THR_W'((level * SCALE_HUNDREDTHS) / FULL_SCALE);
        endcase
    endfunction

    function automatic logic [COUNT_CFG_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COUNT_CFG_W'(1);
            2: return COUNT_CFG_W'(16);
            3: return COUNT_CFG_W'(17);
            4: return '1;
            default: return COUNT_CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    initial
    begin
        logic [SAMPLE_W-1:0] directed[$];
        logic [THR_W-1:0]    hthr;
        logic [THR_W-1:0]    lthr;
        logic [COUNT_CFG_W-1:0] cnt;
        bit                  scan_on;
        int                  phase;
        int                  align;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reg(REG_SCAN_ENABLED, 32'(SCAN_ENABLED_RST));
        check_reg(REG_SENSOR_COUNT, 32'(SENSOR_COUNT_RST));
        check_reg(REG_HIGH_THRESHOLD, 32'(HIGH_THRESHOLD_RST));
        check_reg(REG_LOW_THRESHOLD, 32'(LOW_THRESHOLD_RST));

        // disabled scan drops samples
        program_reg(REG_SCAN_ENABLED, 32'd0);
        pending_samples.push_back(12'hFFF);
        queue_noise(5, 0);
        wait_idle();
        program_reg(REG_SCAN_ENABLED, 32'd1);

        directed = '{12'h000, 12'hFFF, 12'hAAA, 12'h555};
        for (int k = 0; k < SAMPLE_W; k++)
            directed.push_back(SAMPLE_W'(1) << k);
        foreach (directed[k])
            pending_samples.push_back(directed[k]);
        items_queued += directed.size();
        queue_noise(SAMPLES_DEF - directed.size(), 1);
        queue_block(0, 0);
        queue_block(4095, 0);

        phase = 0;
        while (items_queued < ITEM_TARGET || readings_seen < READING_TARGET)
        begin
            wait_idle();
            scan_on = (phase == PRESSURE_PHASE) || ($urandom_range(0, 7) != 0);
            program_reg(REG_SCAN_ENABLED, 32'(scan_on));
            if (phase == 0)
            begin
                cnt = COUNT_CFG_W'(17);
                hthr = '1;
                lthr = '0;
            end
            else if (phase == 1)
            begin
                cnt = '0;
                hthr = '0;
                lthr = '1;
            end
            else
            begin
                cnt = pick_count();
                hthr = pick_threshold(hi_level);
                lthr = pick_threshold(lo_level);
            end
            if (phase < 2 || $urandom_range(0, 1))
                program_reg(REG_SENSOR_COUNT, 32'(cnt));
            if (phase < 2 || $urandom_range(0, 1))
                program_reg(REG_HIGH_THRESHOLD, 32'(hthr));
            if (phase < 2 || $urandom_range(0, 1))
                program_reg(REG_LOW_THRESHOLD, 32'(lthr));

            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;

            if (!scan_on)
            begin
                queue_noise($urandom_range(1, 40), 0);
            end
            else if (phase == PRESSURE_PHASE)
            begin
                // receiver holds off while samples stream in back to back
                tx_gap_max = 0;
                rx_stall_len = STALL_CYCLES;
                rx_stall_requests++;
                repeat (20) queue_block(pick_level(), pick_spread());
            end
            else
            begin
                align = (SAMPLES_DEF - acc_count) % SAMPLES_DEF;
                if ($urandom_range(0, 3) != 0)
                    queue_noise(align, 1);
                repeat ($urandom_range(2, 6)) queue_block(pick_level(), pick_spread());
                if ($urandom_range(0, 2) == 0)
                    queue_noise($urandom_range(1, 63), 1);
            end
            phase++;
        end

        wait_idle();
        if (error_count == 0 && expected_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
